FILE: rtl/prrm_pkg.sv
// Shared types, codes and small arithmetic helpers for the pixel recolor block.
// No dependencies; used by rtl/pixel_recolor_replace_or_mix.sv.
`default_nettype none

package prrm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE         = 2'd0;
    localparam logic [1:0] CFG_RED_TARGET   = 2'd1;
    localparam logic [1:0] CFG_GREEN_TARGET = 2'd2;
    localparam logic [1:0] CFG_BLUE_TARGET  = 2'd3;

    // Recolor mode codes; the unused code behaves as none
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_REPLACE = 2'd1;
    localparam logic [1:0] MODE_MIX     = 2'd2;

    // Opcode of an input word
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // Largest table the 4-bit slot field can address
    localparam int SLOT_FIELD_DEPTH = 16;

    // What a word in flight turns into at the output
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_REPLACE,
        KIND_MIX,
        KIND_LOAD
    } kind_t;

    // Pick one 16-bit channel out of a packed red/green/blue color
    function automatic logic [15:0] chan(input logic [47:0] packed_color,
                                         input logic [1:0] sel);
        logic [15:0] c;
        case (sel)
            2'd0:    c = packed_color[47:32];
            2'd1:    c = packed_color[31:16];
            2'd2:    c = packed_color[15:0];
            default: c = 16'd0;
        endcase
        return c;
    endfunction

    // floor(n / 255) for n below 65535 * 255: multiply by 0x1010102, keep bits 47:32
    function automatic logic [15:0] div255(input logic [23:0] n);
        logic [48:0] sum;
        sum = {1'b0, n, 24'd0} + {9'd0, n, 16'd0} + {17'd0, n, 8'd0} + {24'd0, n, 1'b0};
        return sum[47:32];
    endfunction

    // floor(x / 257): x = 257*hi + (lo - hi), so subtract one when lo < hi
    function automatic logic [7:0] div257(input logic [15:0] x);
        logic [7:0] q;
        q = x[15:8] - {7'd0, (x[7:0] < x[15:8])};
        return q;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pixel_recolor_replace_or_mix.sv
// Each word passes through 4 register stages (A, B, C, D) between input and output.
// One word is accepted per cycle; an output stall freezes all stages and raises in_stall.
// The replace table is a row of registers compared in parallel in stage B.
// Reset: pipeline empty, table empty (all slots invalid), config registers zero.
// Depends on rtl/prrm_pkg.sv.
`default_nettype none

module pixel_recolor_replace_or_mix #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [7:0]  pixel_red,
    input  wire logic [7:0]  pixel_green,
    input  wire logic [7:0]  pixel_blue,
    input  wire logic [3:0]  entry_slot,
    input  wire logic [47:0] entry_key,
    input  wire logic [47:0] entry_replacement,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic             was_recolored,
    output logic             load_rejected
);

    // Slots beyond the reach of the slot field are never written
    localparam int SLOTS = (TABLE_ENTRIES < prrm_pkg::SLOT_FIELD_DEPTH)
                         ? TABLE_ENTRIES : prrm_pkg::SLOT_FIELD_DEPTH;

    logic        adv;

    // Configuration registers
    logic [1:0]  mode_reg;
    logic [47:0] red_target_reg;
    logic [47:0] green_target_reg;
    logic [47:0] blue_target_reg;

    // Replace table
    logic [SLOTS-1:0] slot_valid_reg;
    logic [47:0]      slot_key_reg [SLOTS];
    logic [47:0]      slot_rep_reg [SLOTS];

    // Stage A: captured input word
    logic        valid_a_reg;
    logic        op_a_reg;
    logic [7:0]  pix_a_reg [3];
    logic [3:0]  slot_a_reg;
    logic [47:0] key_a_reg;
    logic [47:0] rep_a_reg;

    // Stage B: table result and raw products
    logic                valid_b_reg;
    prrm_pkg::kind_t     kind_b_reg;
    logic                rej_b_reg;
    logic [7:0]          pix_b_reg [3];
    logic [47:0]         hit_rep_b_reg;
    logic [23:0]         prod_b_reg [3][3];

    // Stage C: scaled terms and the non-mix result
    logic                valid_c_reg;
    prrm_pkg::kind_t     kind_c_reg;
    logic                rej_c_reg;
    logic [7:0]          pre_c_reg [3];
    logic [15:0]         term_c_reg [3][3];

    // Stage D: output word
    logic        out_valid_reg;
    logic [7:0]  out_pix_reg [3];
    logic        recolored_reg;
    logic        rejected_reg;

    // Stage B combinational
    logic [47:0]      cmp_key;
    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] own;
    logic             slot_ok;
    logic             dup;
    logic             hit;
    logic [47:0]      hit_rep;
    logic             tbl_we;
    prrm_pkg::kind_t  kind_b_next;
    logic [23:0]      prod_b_next [3][3];

    // Stage C and D combinational
    logic [7:0]  pre_c_next [3];
    logic [15:0] term_c_next [3][3];
    logic [7:0]  mix_d_next [3];
    logic [7:0]  out_pix_next [3];

    // Whole pipeline moves unless a finished word is held by the receiver
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= prrm_pkg::MODE_NONE;
            red_target_reg   <= 48'd0;
            green_target_reg <= 48'd0;
            blue_target_reg  <= 48'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                prrm_pkg::CFG_MODE:         mode_reg         <= cfg_data[1:0];
                prrm_pkg::CFG_RED_TARGET:   red_target_reg   <= cfg_data;
                prrm_pkg::CFG_GREEN_TARGET: green_target_reg <= cfg_data;
                prrm_pkg::CFG_BLUE_TARGET:  blue_target_reg  <= cfg_data;
                default:                    mode_reg         <= mode_reg;
            endcase
        end
    end

    // Stage A: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else if (adv)
            valid_a_reg <= in_valid;
    end

    // Stage A: payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_a_reg    <= opcode;
            pix_a_reg[0] <= pixel_red;
            pix_a_reg[1] <= pixel_green;
            pix_a_reg[2] <= pixel_blue;
            slot_a_reg  <= entry_slot;
            key_a_reg   <= entry_key;
            rep_a_reg   <= entry_replacement;
        end
    end

    // Stage B: compare every slot against the load key or the expanded pixel
    always_comb
    begin
        cmp_key = (op_a_reg == prrm_pkg::OP_LOAD) ? key_a_reg
                : {pix_a_reg[0], pix_a_reg[0], pix_a_reg[1], pix_a_reg[1],
                   pix_a_reg[2], pix_a_reg[2]};
        hit_rep = 48'd0;
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = slot_valid_reg[i] && (slot_key_reg[i] == cmp_key);
            own[i]   = (slot_a_reg == 4'(i));
            // Keys are unique among valid slots, so at most one row is selected
            hit_rep  = hit_rep | (slot_rep_reg[i] & {48{match[i]}});
        end
        slot_ok = ({1'b0, slot_a_reg} < 5'(SLOTS));
        dup     = |(match & ~own);
        hit     = |match;
        tbl_we  = adv && valid_a_reg && (op_a_reg == prrm_pkg::OP_LOAD) && slot_ok && !dup;

        if (op_a_reg == prrm_pkg::OP_LOAD)
            kind_b_next = prrm_pkg::KIND_LOAD;
        else if (mode_reg == prrm_pkg::MODE_REPLACE && hit)
            kind_b_next = prrm_pkg::KIND_REPLACE;
        else if (mode_reg == prrm_pkg::MODE_MIX)
            kind_b_next = prrm_pkg::KIND_MIX;
        else
            kind_b_next = prrm_pkg::KIND_PASS;

        // Product of output channel c of target k with input channel k
        for (int c = 0; c < 3; c++)
        begin
            prod_b_next[c][0] = 24'(prrm_pkg::chan(red_target_reg, 2'(c))) * 24'(pix_a_reg[0]);
            prod_b_next[c][1] = 24'(prrm_pkg::chan(green_target_reg, 2'(c))) * 24'(pix_a_reg[1]);
            prod_b_next[c][2] = 24'(prrm_pkg::chan(blue_target_reg, 2'(c))) * 24'(pix_a_reg[2]);
        end
    end

    // Table valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= '0;
        else if (tbl_we)
            slot_valid_reg <= slot_valid_reg | own;
    end

    // Table keys and replacements
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_we && own[i])
            begin
                slot_key_reg[i] <= key_a_reg;
                slot_rep_reg[i] <= rep_a_reg;
            end
        end
    end

    // Stage B: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_b_reg <= 1'b0;
        else if (adv)
            valid_b_reg <= valid_a_reg;
    end

    // Stage B: payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_b_reg    <= kind_b_next;
            rej_b_reg     <= (op_a_reg == prrm_pkg::OP_LOAD) && slot_ok && dup;
            pix_b_reg     <= pix_a_reg;
            hit_rep_b_reg <= hit_rep;
            prod_b_reg    <= prod_b_next;
        end
    end

    // Stage C: scale products by 1/255, form the pass, replace or load result
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 3; k++)
                term_c_next[c][k] = prrm_pkg::div255(prod_b_reg[c][k]);
            case (kind_b_reg)
                prrm_pkg::KIND_REPLACE:
                    pre_c_next[c] = prrm_pkg::div257(prrm_pkg::chan(hit_rep_b_reg, 2'(c)));
                prrm_pkg::KIND_LOAD:
                    pre_c_next[c] = 8'd0;
                default:
                    pre_c_next[c] = pix_b_reg[c];
            endcase
        end
    end

    // Stage C: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_c_reg <= 1'b0;
        else if (adv)
            valid_c_reg <= valid_b_reg;
    end

    // Stage C: payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_c_reg <= kind_b_reg;
            rej_c_reg  <= rej_b_reg;
            pre_c_reg  <= pre_c_next;
            term_c_reg <= term_c_next;
        end
    end

    // Stage D: saturating sum of the three terms, then scale by 1/257
    always_comb
    begin
        logic [17:0] sum;
        logic [15:0] sat;
        for (int c = 0; c < 3; c++)
        begin
            sum = 18'(term_c_reg[c][0]) + 18'(term_c_reg[c][1]) + 18'(term_c_reg[c][2]);
            // Terms are never negative, so one clamp at the end equals clamping each add
            sat = (sum[17:16] != 2'd0) ? 16'hFFFF : sum[15:0];
            mix_d_next[c]   = prrm_pkg::div257(sat);
            out_pix_next[c] = (kind_c_reg == prrm_pkg::KIND_MIX) ? mix_d_next[c] : pre_c_reg[c];
        end
    end

    // Output word: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_c_reg;
    end

    // Output word: payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pix_reg   <= out_pix_next;
            recolored_reg <= (kind_c_reg == prrm_pkg::KIND_REPLACE)
                          || (kind_c_reg == prrm_pkg::KIND_MIX);
            rejected_reg  <= rej_c_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_red       = out_pix_reg[0];
    assign out_green     = out_pix_reg[1];
    assign out_blue      = out_pix_reg[2];
    assign was_recolored = recolored_reg;
    assign load_rejected = rejected_reg;

endmodule

`default_nettype wire

FILE: tb/recolor_checker.sv
// Result checker for the pixel recolor block: watches the register port and both word
// channels, mirrors the replace table and the mix targets, and compares every result word.
// Depends on rtl/prrm_pkg.sv for register indexes, mode codes and opcodes.
module recolor_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  pixel_red,
    input  logic [7:0]  pixel_green,
    input  logic [7:0]  pixel_blue,
    input  logic [3:0]  entry_slot,
    input  logic [47:0] entry_key,
    input  logic [47:0] entry_replacement,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_red,
    input  logic [7:0]  out_green,
    input  logic [7:0]  out_blue,
    input  logic        was_recolored,
    input  logic        load_rejected,
    output int          mismatches,
    output int          words_checked,
    output int          recolored_words,
    output int          rejected_loads,
    output int          pending_words
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       recolored;
        logic       rejected;
    } recolored_pixel_t;

    // Pixels still owed by the block, oldest first
    recolored_pixel_t expected_pixels[$];

    // Mirror of the registers and the replace table
    logic [1:0]  mode_reg;
    logic [47:0] target_reg [3];
    logic        slot_valid [TABLE_ENTRIES];
    logic [47:0] slot_key   [TABLE_ENTRIES];
    logic [47:0] slot_repl  [TABLE_ENTRIES];

    int mismatch_total;
    int checked_total;
    int recolored_total;
    int rejected_total;

    // Weighted sum of the three targets for one output channel, saturating after each add
    function automatic logic [7:0] mix_channel(int sel, logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b);
        logic [7:0]  weight [3];
        logic [15:0] target_chan;
        logic [23:0] term;
        logic [16:0] acc;
        int k;
        weight[0] = r;
        weight[1] = g;
        weight[2] = b;
        acc = '0;
        for (k = 0; k < 3; k++)
        begin
            target_chan = target_reg[k][47 - 16 * sel -: 16];
            term = ({8'd0, target_chan} * {16'd0, weight[k]}) / 24'd255;
            acc = acc + {1'b0, term[15:0]};
            if (acc > 17'd65535)
                acc = 17'd65535;
        end
        return 8'(acc / 17'd257);
    endfunction

    // Work out the result of one input word and apply any table load
    function automatic recolored_pixel_t predict_word(logic op, logic [7:0] r, logic [7:0] g,
                                                      logic [7:0] b, logic [3:0] slot,
                                                      logic [47:0] key, logic [47:0] repl);
        recolored_pixel_t res;
        logic [47:0] color;
        int i;
        res = '{red: r, green: g, blue: b, recolored: 1'b0, rejected: 1'b0};
        if (op == prrm_pkg::OP_LOAD)
        begin
            res = '0;
            if (int'(slot) < TABLE_ENTRIES)
            begin
                // refuse a key already held by some other valid slot
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (i != int'(slot) && slot_valid[i] && slot_key[i] == key)
                        res.rejected = 1'b1;
                if (!res.rejected)
                begin
                    slot_valid[slot] = 1'b1;
                    slot_key[slot]   = key;
                    slot_repl[slot]  = repl;
                end
            end
        end
        else if (mode_reg == prrm_pkg::MODE_REPLACE)
        begin
            // p * 257 is the byte written twice
            color = {r, r, g, g, b, b};
            // scan downward so the lowest matching slot is applied last
            for (i = TABLE_ENTRIES - 1; i >= 0; i--)
                if (slot_valid[i] && slot_key[i] == color)
                begin
                    res.red       = 8'(slot_repl[i][47:32] / 16'd257);
                    res.green     = 8'(slot_repl[i][31:16] / 16'd257);
                    res.blue      = 8'(slot_repl[i][15:0] / 16'd257);
                    res.recolored = 1'b1;
                end
        end
        else if (mode_reg == prrm_pkg::MODE_MIX)
        begin
            res.red       = mix_channel(0, r, g, b);
            res.green     = mix_channel(1, r, g, b);
            res.blue      = mix_channel(2, r, g, b);
            res.recolored = 1'b1;
        end
        return res;
    endfunction

    task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatch_total++;
        end
    endtask

    // Check outgoing words, track register writes, predict incoming words
    always @(posedge clk or negedge rst_n)
    begin : watch
        recolored_pixel_t want;
        int i;
        if (!rst_n)
        begin
            expected_pixels.delete();
            mode_reg = prrm_pkg::MODE_NONE;
            for (i = 0; i < 3; i++)
                target_reg[i] = '0;
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_repl[i]  = '0;
            end
            mismatch_total  = 0;
            checked_total   = 0;
            recolored_total = 0;
            rejected_total  = 0;
            mismatches      <= 0;
            words_checked   <= 0;
            recolored_words <= 0;
            rejected_loads  <= 0;
            pending_words   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result word with nothing expected: red %0d green %0d blue %0d",
                           out_red, out_green, out_blue);
                    mismatch_total++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    compare_field("out_red", want.red, out_red);
                    compare_field("out_green", want.green, out_green);
                    compare_field("out_blue", want.blue, out_blue);
                    compare_field("was_recolored", {7'd0, want.recolored}, {7'd0, was_recolored});
                    compare_field("load_rejected", {7'd0, want.rejected}, {7'd0, load_rejected});
                    checked_total++;
                    if (want.recolored)
                        recolored_total++;
                    if (want.rejected)
                        rejected_total++;
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    prrm_pkg::CFG_MODE:         mode_reg = cfg_data[1:0];
                    prrm_pkg::CFG_RED_TARGET:   target_reg[0] = cfg_data;
                    prrm_pkg::CFG_GREEN_TARGET: target_reg[1] = cfg_data;
                    prrm_pkg::CFG_BLUE_TARGET:  target_reg[2] = cfg_data;
                    default:                    ;
                endcase
            end

            if (in_valid && !in_stall)
                expected_pixels.push_back(predict_word(opcode, pixel_red, pixel_green,
                                                       pixel_blue, entry_slot, entry_key,
                                                       entry_replacement));

            mismatches      <= mismatch_total;
            words_checked   <= checked_total;
            recolored_words <= recolored_total;
            rejected_loads  <= rejected_total;
            pending_words   <= expected_pixels.size();
        end
    end

endmodule

FILE: tb/tb_pixel_recolor_replace_or_mix.sv
// Testbench top for pixel_recolor_replace_or_mix: clock, reset, register writes, input
// words and output stalls; the verdict comes from the failure count of tb/recolor_checker.sv.
// Depends on rtl/prrm_pkg.sv and rtl/pixel_recolor_replace_or_mix.sv.
module tb_pixel_recolor_replace_or_mix;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PHASES       = 12;
    localparam int          PHASE_WORDS  = 145;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam logic [47:0] ALL_ONES     = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0]  PHASE_MODES [PHASES] = '{
        prrm_pkg::MODE_REPLACE, prrm_pkg::MODE_MIX, prrm_pkg::MODE_NONE,
        prrm_pkg::MODE_REPLACE, prrm_pkg::MODE_MIX, MODE_UNUSED,
        prrm_pkg::MODE_REPLACE, prrm_pkg::MODE_MIX, prrm_pkg::MODE_REPLACE,
        prrm_pkg::MODE_NONE, prrm_pkg::MODE_MIX, prrm_pkg::MODE_REPLACE
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [3:0]  entry_slot;
    logic [47:0] entry_key;
    logic [47:0] entry_replacement;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        was_recolored;
    logic        load_rejected;

    int mismatches;
    int words_checked;
    int recolored_words;
    int rejected_loads;
    int pending_words;
    int cycle_count = 0;

    bit tx_idling;
    bit rx_idling;
    bit hold_off_request;

    pixel_recolor_replace_or_mix uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .pixel_red         (pixel_red),
        .pixel_green       (pixel_green),
        .pixel_blue        (pixel_blue),
        .entry_slot        (entry_slot),
        .entry_key         (entry_key),
        .entry_replacement (entry_replacement),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_red           (out_red),
        .out_green         (out_green),
        .out_blue          (out_blue),
        .was_recolored     (was_recolored),
        .load_rejected     (load_rejected)
    );

    recolor_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .pixel_red         (pixel_red),
        .pixel_green       (pixel_green),
        .pixel_blue        (pixel_blue),
        .entry_slot        (entry_slot),
        .entry_key         (entry_key),
        .entry_replacement (entry_replacement),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_red           (out_red),
        .out_green         (out_green),
        .out_blue          (out_blue),
        .was_recolored     (was_recolored),
        .load_rejected     (load_rejected),
        .mismatches        (mismatches),
        .words_checked     (words_checked),
        .recolored_words   (recolored_words),
        .rejected_loads    (rejected_loads),
        .pending_words     (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Expand an 8-bit-per-channel color to the 16-bit-per-channel key form
    function automatic logic [47:0] key_of(logic [23:0] rgb);
        return {rgb[23:16], rgb[23:16], rgb[15:8], rgb[15:8], rgb[7:0], rgb[7:0]};
    endfunction

    function automatic logic [47:0] random48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Offer one word, maybe after an idle burst, and hold it until accepted
    task automatic send_word(logic op, logic [23:0] rgb, logic [3:0] slot, logic [47:0] key,
                             logic [47:0] repl);
        if (tx_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        opcode            <= op;
        pixel_red         <= rgb[23:16];
        pixel_green       <= rgb[15:8];
        pixel_blue        <= rgb[7:0];
        entry_slot        <= slot;
        entry_key         <= key;
        entry_replacement <= repl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_pixel(logic [23:0] rgb);
        send_word(prrm_pkg::OP_PIXEL, rgb, 4'($urandom), random48(), random48());
    endtask

    task automatic send_load(logic [3:0] slot, logic [47:0] key, logic [47:0] repl);
        send_word(prrm_pkg::OP_LOAD, 24'($urandom), slot, key, repl);
    endtask

    // Drop valid and wait until every result word is back and the pipeline has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back; call only when idle
    task automatic configure(logic [1:0] mode, logic [47:0] red_t, logic [47:0] green_t,
                             logic [47:0] blue_t);
        cfg_write <= 1'b1;
        cfg_index <= prrm_pkg::CFG_MODE;
        cfg_data  <= {46'd0, mode};
        @(posedge clk);
        cfg_index <= prrm_pkg::CFG_RED_TARGET;
        cfg_data  <= red_t;
        @(posedge clk);
        cfg_index <= prrm_pkg::CFG_GREEN_TARGET;
        cfg_data  <= green_t;
        @(posedge clk);
        cfg_index <= prrm_pkg::CFG_BLUE_TARGET;
        cfg_data  <= blue_t;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Output side: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
                out_stall <= 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        logic [23:0] palette [8];
        logic [47:0] targets [3];
        logic [47:0] load_key;
        int ph;
        int n;
        int k;
        int roll;

        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = prrm_pkg::CFG_MODE;
        cfg_data          = '0;
        in_valid          = 1'b0;
        opcode            = prrm_pkg::OP_PIXEL;
        pixel_red         = '0;
        pixel_green       = '0;
        pixel_blue        = '0;
        entry_slot        = '0;
        entry_key         = '0;
        entry_replacement = '0;
        tx_idling         = 1'b1;
        rx_idling         = 1'b1;
        hold_off_request  = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through with registers at reset
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);

        // Table loads: plain, duplicate key elsewhere, same-slot rewrite, zero key
        send_load(4'd0, key_of(24'h0A141E), 48'hFFFF_0000_8080);
        send_load(4'd15, key_of(24'hFFFFFF), 48'h0);
        send_load(4'd3, key_of(24'h0A141E), random48());
        send_load(4'd0, key_of(24'h0A141E), 48'h0101_0202_FFFE);
        send_load(4'd5, 48'h0, ALL_ONES);
        wait_idle();

        // Replace: hits on the loaded keys and one miss
        configure(prrm_pkg::MODE_REPLACE, '0, '0, '0);
        send_pixel(24'h0A141E);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        send_pixel(24'h010203);
        wait_idle();

        // Mix with full targets saturates; then one target per channel
        configure(prrm_pkg::MODE_MIX, ALL_ONES, ALL_ONES, ALL_ONES);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        send_pixel(24'h804001);
        wait_idle();
        configure(prrm_pkg::MODE_MIX, 48'hFFFF_0000_0000, 48'h0000_FFFF_0000,
                  48'h0000_0000_FFFF);
        send_pixel(24'hC86432);
        wait_idle();

        // Unused mode code passes the pixel through
        configure(MODE_UNUSED, random48(), random48(), random48());
        send_pixel(24'h55AA0F);
        wait_idle();

        // Random phases: mostly palette colors so replace hits and duplicate loads are common
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 3)
                0:
                begin
                    targets[0] = ALL_ONES;
                    targets[1] = ALL_ONES;
                    targets[2] = ALL_ONES;
                end
                1:
                begin
                    targets[0] = random48();
                    targets[1] = random48();
                    targets[2] = random48();
                end
                default:
                begin
                    targets[0] = '0;
                    targets[1] = random48();
                    targets[2] = ALL_ONES;
                end
            endcase
            tx_idling = (ph != PHASES - 1) && (ph % 4 != 2);
            rx_idling = (ph != PHASES - 1) && (ph % 4 != 1);
            configure(PHASE_MODES[ph], targets[0], targets[1], targets[2]);

            // Fill the pipeline behind a long output hold-off
            if (ph == 4)
            begin
                tx_idling = 1'b0;
                hold_off_request = 1'b1;
            end

            for (k = 0; k < 8; k++)
                palette[k] = 24'($urandom);
            if (ph % 2 == 0)
                palette[0] = 24'h000000;
            else
                palette[1] = 24'hFFFFFF;

            for (n = 0; n < PHASE_WORDS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                begin
                    k = $urandom_range(0, 7);
                    if (roll < 11)
                        load_key = key_of(palette[k]);
                    else if (roll < 13)
                        load_key = random48();
                    else
                        load_key = key_of(24'($urandom));
                    send_load(4'($urandom), load_key,
                              ($urandom_range(0, 9) == 0) ? ALL_ONES : random48());
                end
                else if (roll < 70)
                    send_pixel(palette[$urandom_range(0, 7)]);
                else
                    send_pixel(24'($urandom));
            end
            wait_idle();
        end

        $display("Covered %0d result words over all four mode codes: %0d recolored, %0d %s",
                 words_checked, recolored_words, rejected_loads, "loads refused.");
        $display("Both channels idled at random, with one long output hold-off and a gap-free tail.");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
